// ===== src/truncated_binary_bit_packer_core_defines.svh =====
// Assertion macros for the truncated binary bit packer.
`ifndef TRUNCATED_BINARY_BIT_PACKER_CORE_DEFINES_SVH
`define TRUNCATED_BINARY_BIT_PACKER_CORE_DEFINES_SVH

// Plain property, checked at every rising clock edge out of reset.
`define TBP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tbp assertion failed");

// Next-cycle implication.
`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbp assertion failed");

`endif

// ===== src/tbp_pkg.sv =====
// Shared types, constants and helpers of the truncated binary bit packer.
package tbp_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned LenW      = 6;
  localparam int unsigned AccW      = 39;
  localparam int unsigned TotW      = 6;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic {
    CmdEncode = 1'b0,
    CmdFlush  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DataW-1:0]  code;
    logic [LenW-1:0]   len;
  } code_t;

  typedef struct packed {
    logic [TotW-1:0] total;
  } back_stat_t;

  // Position of the highest set bit, counting from 1; 0 for zero.
  function automatic logic [LenW-1:0] top_bit_pos(input logic [DataW-1:0] x);
    logic [LenW-1:0] pos;
    pos = '0;
    for (int i = 0; i < DataW; i++) begin
      if (x[i]) pos = LenW'(i + 1);
    end
    return pos;
  endfunction

endpackage

// ===== src/tbp_front.sv =====
// Front end: accepts transactions and turns each into a code word and length.
module tbp_front
  import tbp_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [DataW-1:0] value_i,
  input  logic [DataW-1:0] outof_i,
  output logic             code_valid_o,
  input  logic             code_ready_i,
  output code_t            code_o
);

  localparam logic [DataW-1:0] WordMask =
    (WORD_BITS >= DataW) ? {DataW{1'b1}} : DataW'((65'd1 << WORD_BITS) - 65'd1);

  logic en;

  // stage 1: masked operands, outof - 1
  logic             s1_v_q;
  cmd_e             s1_cmd_q;
  logic [DataW-1:0] s1_val_q, s1_om1_q;
  logic [DataW-1:0] val_m, oof_m, om1_d;

  // stage 2: saturated value, bit count, spare
  logic             s2_v_q;
  cmd_e             s2_cmd_q;
  logic [DataW-1:0] s2_vsat_q, s2_om1_q, s2_spare_q;
  logic [LenW-1:0]  s2_bits_q;
  logic [DataW-1:0] vsat_d, bmask_d, spare_d;
  logic [LenW-1:0]  bits_d;

  // stage 3: band thresholds
  logic             s3_v_q;
  cmd_e             s3_cmd_q;
  logic [DataW-1:0] s3_vsat_q, s3_mid_q;
  logic [DataW:0]   s3_hi_q;
  logic [LenW-1:0]  s3_bits_q;
  logic             s3_spnz_q;
  logic [DataW:0]   outof_w;
  logic [DataW-1:0] mid_d;
  logic [DataW:0]   hi_d;

  // code formation
  logic             sel_hi, sel_mid;
  logic [DataW-1:0] diff, raw, lmask;
  logic [LenW-1:0]  len;

  assign en           = !s3_v_q || code_ready_i;
  assign in_ready_o   = en;
  assign code_valid_o = s3_v_q;

  assign val_m = value_i & WordMask;
  assign oof_m = outof_i & WordMask;
  assign om1_d = (oof_m == '0) ? '0 : oof_m - DataW'(1);

  assign vsat_d  = (s1_val_q > s1_om1_q) ? s1_om1_q : s1_val_q;
  assign bits_d  = top_bit_pos(s1_om1_q);
  assign bmask_d = DataW'(((DataW+1)'(1)) << bits_d) - DataW'(1);
  assign spare_d = s1_om1_q ^ bmask_d;

  assign outof_w = {1'b0, s2_om1_q} + (DataW+1)'(1);
  assign mid_d   = DataW'((outof_w - {1'b0, s2_spare_q}) >> 1);
  assign hi_d    = (DataW+1)'(({1'b0, outof_w} + (DataW+2)'(s2_spare_q)) >> 1);

  always_comb begin
    sel_hi  = s3_spnz_q && ({1'b0, s3_vsat_q} >= s3_hi_q);
    sel_mid = s3_spnz_q && !sel_hi && (s3_vsat_q >= s3_mid_q);
    diff    = DataW'({1'b0, s3_vsat_q} - s3_hi_q);
    raw     = sel_hi ? (diff | (DataW'(1) << (s3_bits_q - LenW'(1)))) : s3_vsat_q;
    len     = sel_mid ? (s3_bits_q - LenW'(1)) : s3_bits_q;
    lmask   = DataW'(((DataW+1)'(1) << len) - (DataW+1)'(1));
    if (s3_cmd_q == CmdFlush) begin
      code_o = '{cmd: CmdFlush, code: '0, len: '0};
    end else begin
      code_o = '{cmd: CmdEncode, code: raw & lmask, len: len};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q   <= cmd_e'(command_i);
      s1_val_q   <= val_m;
      s1_om1_q   <= om1_d;
      s2_cmd_q   <= s1_cmd_q;
      s2_vsat_q  <= vsat_d;
      s2_om1_q   <= s1_om1_q;
      s2_spare_q <= spare_d;
      s2_bits_q  <= bits_d;
      s3_cmd_q   <= s2_cmd_q;
      s3_vsat_q  <= s2_vsat_q;
      s3_mid_q   <= mid_d;
      s3_hi_q    <= hi_d;
      s3_bits_q  <= s2_bits_q;
      s3_spnz_q  <= (s2_spare_q != '0);
    end
  end

endmodule

// ===== src/tbp_fifo.sv =====
// Short queue of code words between front and back.
module tbp_fifo
  import tbp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  code_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output code_t rd_data_o,
  output logic [$clog2(FifoDepth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FifoDepth - 1);

  code_t            mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntW'(FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = cnt_q;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    if (push && !pop) cnt_d = cnt_q + CntW'(1);
    else if (pop && !push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== src/tbp_back.sv =====
// Back end: bit accumulator that packs code words and emits bytes.
module tbp_back
  import tbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       code_valid_i,
  output logic       code_ready_o,
  input  code_t      code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output back_stat_t stat_o
);

  logic [AccW-1:0] acc_q, acc_d;
  logic [TotW-1:0] tot_q, tot_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            out_free, emit, pop;

  assign out_free     = !out_valid_q || out_ready_i;
  assign emit         = (tot_q >= TotW'(8)) && out_free;
  assign code_ready_o = (tot_q < TotW'(8));
  assign pop          = code_ready_o && code_valid_i;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign last_o       = last_q;
  assign stat_o       = '{total: tot_q};

  always_comb begin
    acc_d = acc_q;
    tot_d = tot_q;
    if (emit) begin
      acc_d = acc_q >> 8;
      tot_d = tot_q - TotW'(8);
    end else if (pop) begin
      if (code_i.cmd == CmdFlush) begin
        acc_d = {{(AccW-7){1'b0}}, acc_q[6:0]};
        tot_d = (tot_q != '0) ? TotW'(8) : '0;
      end else begin
        acc_d = {{(AccW-7){1'b0}}, acc_q[6:0]} | (AccW'(code_i.code) << tot_q[2:0]);
        tot_d = {{(TotW-3){1'b0}}, tot_q[2:0]} + code_i.len;
      end
    end
  end

  always_comb begin
    if (emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      tot_q       <= tot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= acc_q[7:0];
      last_q <= (tot_q < TotW'(16));
    end
  end

endmodule

// ===== src/truncated_binary_bit_packer_core.sv =====
// Top level of the truncated binary bit packer.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------
//  in      | in_valid_i/in_ready_o | command_i, value_i, outof_i
//  out     | out_valid_o/out_ready_i | out_byte_o, last_o
//
// The front end takes a transaction per cycle unless stalled; code forming is
// registered in stages s1, s2 and s3. The back accumulator loads a code word,
// then emits bytes one at a time; it takes no new word while a byte is pending.
// Reset clears the pending bits and all valid flags; no clearing pass.
// A stalled output holds the back end, which fills the queue and then
// stalls the front end.
`include "truncated_binary_bit_packer_core_defines.svh"

module truncated_binary_bit_packer_core
  import tbp_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [DataW-1:0] value_i,
  input  logic [DataW-1:0] outof_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  logic       f_valid, f_ready, b_valid, b_ready;
  code_t      f_code, b_code;
  back_stat_t back_stat;
  logic [$clog2(FifoDepth+1)-1:0] q_count;

  tbp_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .outof_i     (outof_i),
    .code_valid_o(f_valid),
    .code_ready_i(f_ready),
    .code_o      (f_code)
  );

  tbp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_code),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_code),
    .count_o   (q_count)
  );

  tbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .code_valid_i(b_valid),
    .code_ready_o(b_ready),
    .code_i      (b_code),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .stat_o      (back_stat)
  );

  `TBP_ASSERT(a_tot_bound, clk_i, rst_ni, back_stat.total <= TotW'(AccW))
  `TBP_ASSERT(a_queue_bound, clk_i, rst_ni, q_count <= ($clog2(FifoDepth+1))'(FifoDepth))
  `TBP_ASSERT_NEXT(a_byte_drain, clk_i, rst_ni, back_stat.total >= TotW'(8) && !out_valid_o, back_stat.total == $past(back_stat.total) - TotW'(8))

endmodule
